FILE: sv/gltc_pkg.sv
package gltc_pkg;

    localparam int unsigned TIME_W = 63;
    localparam int unsigned LEVEL_W = 16;
    localparam int unsigned SPAN_W = 32;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_THRESHOLD    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_BAND         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MOISTURE_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SYSTEM_ENABLE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PUMP_RUN_US        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PUMP_COOLDOWN_US   = 3'd5;

    localparam logic [LEVEL_W-1:0] RST_LIGHT_THRESHOLD    = 16'd90;
    localparam logic [LEVEL_W-1:0] RST_LIGHT_BAND         = 16'd20;
    localparam logic [LEVEL_W-1:0] RST_MOISTURE_THRESHOLD = 16'd100;
    localparam logic               RST_SYSTEM_ENABLE      = 1'b1;
    localparam logic [SPAN_W-1:0]  RST_PUMP_RUN_US        = 32'd10000000;
    localparam logic [SPAN_W-1:0]  RST_PUMP_COOLDOWN_US   = 32'd60000000;

    typedef struct packed {
        logic [LEVEL_W-1:0] light_threshold;
        logic [LEVEL_W-1:0] light_band;
        logic [LEVEL_W-1:0] moisture_threshold;
        logic               system_enable;
        logic [SPAN_W-1:0]  pump_run_us;
        logic [SPAN_W-1:0]  pump_cooldown_us;
    } t_cfg;

    typedef struct packed {
        logic [TIME_W-1:0]  now_us;
        logic               frame_valid;
        logic [LEVEL_W-1:0] lux_level;
        logic [LEVEL_W-1:0] moisture_level;
        logic               water_present;
    } t_item;

    // True when at least span microseconds have passed since the start time.
    function automatic logic elapsed_reached(
        input logic [TIME_W-1:0] now,
        input logic [TIME_W-1:0] since,
        input logic [SPAN_W-1:0] span
    );
        logic [TIME_W-1:0] diff;
        diff = now - since;
        return (now >= since) && (diff >= {{(TIME_W-SPAN_W){1'b0}}, span});
    endfunction

endpackage

FILE: sv/gltc_ctrl.sv
module gltc_ctrl
    import gltc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_step,
    input  t_cfg  i_cfg,
    input  t_item i_item,
    output logic  o_pump_on,
    output logic  o_light_on
);

    logic              r_pump_active;
    logic              r_light_active;
    logic              r_cooling_down;
    logic [TIME_W-1:0] r_pump_started_at;
    logic [TIME_W-1:0] r_cooldown_started_at;

    logic              n_pump_active;
    logic              n_light_active;
    logic              n_cooling_down;
    logic [TIME_W-1:0] n_pump_started_at;
    logic [TIME_W-1:0] n_cooldown_started_at;

    logic [LEVEL_W:0]  light_off_level;
    logic              pump_start;
    logic              pump_done;
    logic              cool_done;

    always_comb begin
        light_off_level = {1'b0, i_cfg.light_threshold} + {1'b0, i_cfg.light_band};
        pump_start = !r_pump_active && !r_cooling_down && i_item.water_present
                     && (i_item.moisture_level < i_cfg.moisture_threshold);
        // A run that starts in this step has zero elapsed time.
        pump_done = pump_start ? (i_cfg.pump_run_us == '0)
                  : (r_pump_active && elapsed_reached(i_item.now_us, r_pump_started_at,
                                                      i_cfg.pump_run_us));
        cool_done = pump_done ? (i_cfg.pump_cooldown_us == '0)
                  : elapsed_reached(i_item.now_us, r_cooldown_started_at,
                                    i_cfg.pump_cooldown_us);

        n_pump_active         = r_pump_active;
        n_light_active        = r_light_active;
        n_cooling_down        = r_cooling_down;
        n_pump_started_at     = r_pump_started_at;
        n_cooldown_started_at = r_cooldown_started_at;

        if (i_item.frame_valid) begin
            if (!i_cfg.system_enable) begin
                n_pump_active  = 1'b0;
                n_light_active = 1'b0;
            end else begin
                if (i_item.lux_level < i_cfg.light_threshold) begin
                    n_light_active = 1'b1;
                end else if ({1'b0, i_item.lux_level} > light_off_level) begin
                    n_light_active = 1'b0;
                end
                if (pump_start) begin
                    n_pump_active     = 1'b1;
                    n_pump_started_at = i_item.now_us;
                end
                if (pump_done) begin
                    n_pump_active         = 1'b0;
                    n_cooling_down        = 1'b1;
                    n_cooldown_started_at = i_item.now_us;
                end
                if ((r_cooling_down || pump_done) && cool_done) begin
                    n_cooling_down = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pump_active         <= 1'b0;
            r_light_active        <= 1'b0;
            r_cooling_down        <= 1'b0;
            r_pump_started_at     <= '0;
            r_cooldown_started_at <= '0;
        end else if (i_step) begin
            r_pump_active         <= n_pump_active;
            r_light_active        <= n_light_active;
            r_cooling_down        <= n_cooling_down;
            r_pump_started_at     <= n_pump_started_at;
            r_cooldown_started_at <= n_cooldown_started_at;
        end
    end

    assign o_pump_on  = n_pump_active;
    assign o_light_on = n_light_active;

`ifndef ASSERT_OFF
    a_pump_not_while_cooling: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_pump_active && r_cooling_down))
        else $error("pump running during cooldown");

    a_disable_forces_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_item.frame_valid && !i_cfg.system_enable)
        |=> (!r_pump_active && !r_light_active))
        else $error("drives not cleared while disabled");

    a_invalid_frame_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && !i_item.frame_valid)
        |=> ($stable(r_pump_active) && $stable(r_light_active) && $stable(r_cooling_down)))
        else $error("state changed on an invalid frame");
`endif

endmodule

FILE: sv/grow_light_and_pump_timer_control_unit.sv
// Grow light and pump timer control. Each input word is one evaluation; each accepted
// word yields exactly one output word with the pump and light drive levels after that
// evaluation. The block takes one word per cycle while the output side does not stall:
// a word is registered at the input, evaluated against the control state as it moves
// on, and its result is held in an output register until taken. Configuration registers
// must be written through the plain write port only while no word is in flight; the
// block itself does not enforce this.
module grow_light_and_pump_timer_control_unit
    import gltc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [TIME_W-1:0]     i_now_us,
    input  logic                  i_frame_valid,
    input  logic [LEVEL_W-1:0]    i_lux_level,
    input  logic [LEVEL_W-1:0]    i_moisture_level,
    input  logic                  i_water_present,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic                  o_pump_on,
    output logic                  o_light_on,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_cfg  r_cfg;
    t_item r_in;
    logic  r_in_valid;
    logic  r_out_valid;
    logic  r_pump_on;
    logic  r_light_on;

    logic  advance;
    logic  in_accept;
    logic  n_pump_on;
    logic  n_light_on;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.light_threshold    <= RST_LIGHT_THRESHOLD;
            r_cfg.light_band         <= RST_LIGHT_BAND;
            r_cfg.moisture_threshold <= RST_MOISTURE_THRESHOLD;
            r_cfg.system_enable      <= RST_SYSTEM_ENABLE;
            r_cfg.pump_run_us        <= RST_PUMP_RUN_US;
            r_cfg.pump_cooldown_us   <= RST_PUMP_COOLDOWN_US;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LIGHT_THRESHOLD:    r_cfg.light_threshold    <= i_cfg_data[LEVEL_W-1:0];
                CFG_LIGHT_BAND:         r_cfg.light_band         <= i_cfg_data[LEVEL_W-1:0];
                CFG_MOISTURE_THRESHOLD: r_cfg.moisture_threshold <= i_cfg_data[LEVEL_W-1:0];
                CFG_SYSTEM_ENABLE:      r_cfg.system_enable      <= i_cfg_data[0];
                CFG_PUMP_RUN_US:        r_cfg.pump_run_us        <= i_cfg_data[SPAN_W-1:0];
                CFG_PUMP_COOLDOWN_US:   r_cfg.pump_cooldown_us   <= i_cfg_data[SPAN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign advance   = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall   = r_in_valid && !advance;
    assign in_accept = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_accept) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in.now_us         <= i_now_us;
            r_in.frame_valid    <= i_frame_valid;
            r_in.lux_level      <= i_lux_level;
            r_in.moisture_level <= i_moisture_level;
            r_in.water_present  <= i_water_present;
        end
    end

    gltc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (advance),
        .i_cfg      (r_cfg),
        .i_item     (r_in),
        .o_pump_on  (n_pump_on),
        .o_light_on (n_light_on)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_pump_on  <= n_pump_on;
            r_light_on <= n_light_on;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_pump_on  = r_pump_on;
    assign o_light_on = r_light_on;

`ifndef ASSERT_OFF
    a_word_moves_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !(r_out_valid && i_stall)) |=> r_out_valid)
        else $error("pending word did not reach the output register");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_out_valid && i_stall))
        else $error("input stalled without a full pipeline");

    a_output_held_when_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> (r_out_valid && $stable(r_pump_on) && $stable(r_light_on)))
        else $error("stalled result changed");
`endif

endmodule
